// File: rtl/latency_histogram_percentile_macros.svh
// Assertion macros for the latency histogram block.
// Used by latency_histogram_percentile.sv; no other dependencies.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_MACROS_SVH
`ifndef SYNTHESIS
`define LHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LHP_ASSERT_NOW(label, ante, cons, msg)
`define LHP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/lhp_pkg.sv
// Constants, operation codes and bucket bounds for the latency histogram.
// No dependencies; imported by latency_histogram_percentile.
package lhp_pkg;

  localparam int NUM_BUCKETS    = 12;
  localparam int BIDX_W         = $clog2(NUM_BUCKETS);
  localparam int COUNT_BITS_DEF = 32;
  localparam int SUM_W          = 48;
  localparam int PCT_W          = 7;
  localparam int PCT_FULL       = 100;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [31:0] BOUND_TAB [NUM_BUCKETS] = '{
    32'd1, 32'd2, 32'd5, 32'd10, 32'd20, 32'd50, 32'd100, 32'd200,
    32'd500, 32'd1000, 32'd2000, 32'h7fff_ffff
  };

  function automatic logic [BIDX_W-1:0] pick_bucket(input logic [31:0] ms);
    logic [BIDX_W-1:0] sel;
    sel = BIDX_W'(NUM_BUCKETS - 1);
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (ms <= BOUND_TAB[i]) begin
        sel = BIDX_W'(i);
      end
    end
    return sel;
  endfunction

endpackage

// File: rtl/latency_histogram_percentile.sv
// Top level of the bucketed latency histogram with percentile query.
// Depends on lhp_pkg and latency_histogram_percentile_macros.svh.
//
// Usage: one input channel (in_*) carries transactions whose tuser holds the
// operation (record, query, clear) and whose tdata holds the sample and the
// percentile. Every accepted transaction yields exactly one result
// transaction on out_*, carrying the bucket index or the percentile answer
// together with the count, sum, minimum and maximum as they stand after it.
// Only one transaction is processed at a time; in_tready is high while the
// sequencer is idle. A record passes through the update state before its
// result is presented. A query on a non-empty histogram loads the first
// bucket and then walks the buckets with one shared accumulate-and-compare
// adder, one bucket per cycle, until a bucket reaches the target or the last
// bucket is met. A clear, an unused operation or a query on an empty
// histogram goes straight to presenting its result.
// The block accepts again once the result enters the output register.
// The result sits in an output register, so a new transaction is accepted
// while an earlier result still waits; if the receiver stalls, the sequencer
// holds its finished result until the output register is free.
// Reset clears all buckets and counters and sets minimum and maximum to -1.
`include "latency_histogram_percentile_macros.svh"

module latency_histogram_percentile
  import lhp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] sample_ms, [39:32] percent
  input  logic [39:0]  in_tdata,
  // [1:0] op
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] bucket_index, [35:4] percentile_ms, [67:36] sample_count,
  // [115:68] latency_sum, [147:116] min_latency, [179:148] max_latency
  output logic [183:0] out_tdata
);

  localparam int C100_W = COUNT_BITS + PCT_W;
  localparam int ACC_W  = C100_W + BIDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REC   = 3'd1;
  localparam logic [2:0] S_QLOAD = 3'd2;
  localparam logic [2:0] S_QWALK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [COUNT_BITS-1:0] counts_r [NUM_BUCKETS];
  logic [COUNT_BITS-1:0] total_r;
  logic [SUM_W-1:0]      sum_r;
  logic [31:0]           lowest_r;
  logic [31:0]           highest_r;
  logic [BIDX_W-1:0]     idx_r;
  logic [30:0]           ms_r;
  logic [C100_W-1:0]     y_r;
  logic [C100_W-1:0]     c100_r;
  logic [ACC_W-1:0]      acc100_r;
  logic [BIDX_W-1:0]     bidx_r;
  logic [31:0]           pres_r;
  logic                  out_tvalid_r;
  logic [183:0]          out_tdata_r;

  logic                  in_acc;
  logic                  out_load;
  logic [1:0]            op;
  logic [31:0]           sample;
  logic [7:0]            pct_raw;
  logic [PCT_W-1:0]      pct;
  logic [31:0]           ms_clamp;
  logic [31:0]           ms32;
  logic [SUM_W:0]        sum_wide;
  logic [ACC_W-1:0]      acc_sum;
  logic                  hit;
  logic                  last;
  logic [BIDX_W-1:0]     idx_inc;
  logic [63:0]           total_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign op        = in_tuser;
  assign sample    = in_tdata[31:0];
  assign pct_raw   = in_tdata[39:32];

  always_comb begin
    if (pct_raw[7]) begin
      pct = '0;
    end else if (pct_raw > 8'(PCT_FULL)) begin
      pct = PCT_W'(PCT_FULL);
    end else begin
      pct = pct_raw[PCT_W-1:0];
    end
  end

  assign ms_clamp  = sample[31] ? 32'd0 : sample;
  assign ms32      = {1'b0, ms_r};
  assign sum_wide  = {1'b0, sum_r} + (SUM_W+1)'(ms32);
  assign acc_sum   = acc100_r + ACC_W'(c100_r);
  assign hit       = (acc_sum >= ACC_W'(y_r)) && (acc_sum != '0);
  assign last      = (idx_r == BIDX_W'(NUM_BUCKETS - 1));
  assign idx_inc   = last ? '0 : idx_r + BIDX_W'(1);
  assign total_ext = 64'(total_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_RECORD) begin
            state_nxt = S_REC;
          end else if (op == OP_QUERY && total_r != '0) begin
            state_nxt = S_QLOAD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_REC:   state_nxt = S_DONE;
      S_QLOAD: state_nxt = S_QWALK;
      S_QWALK: begin
        if (hit || last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      sum_r        <= '0;
      lowest_r     <= '1;
      highest_r    <= '1;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (in_acc && op == OP_CLEAR) begin
        total_r   <= '0;
        sum_r     <= '0;
        lowest_r  <= '1;
        highest_r <= '1;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          counts_r[i] <= '0;
        end
      end
      if (state_r == S_REC) begin
        if (counts_r[idx_r] != '1) begin
          counts_r[idx_r] <= counts_r[idx_r] + COUNT_BITS'(1);
        end
        if (total_r != '1) begin
          total_r <= total_r + COUNT_BITS'(1);
        end
        sum_r <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        if (lowest_r[31] || ms32 < lowest_r) begin
          lowest_r <= ms32;
        end
        if (highest_r[31] || ms32 > highest_r) begin
          highest_r <= ms32;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bidx_r <= '0;
      pres_r <= (op == OP_QUERY && total_r == '0) ? '1 : '0;
      idx_r  <= (op == OP_RECORD) ? pick_bucket(ms_clamp) : '0;
      ms_r   <= ms_clamp[30:0];
      y_r    <= C100_W'(total_r) * C100_W'(pct);
    end
    if (state_r == S_REC) begin
      bidx_r <= idx_r;
    end
    if (state_r == S_QLOAD) begin
      acc100_r <= '0;
      c100_r   <= C100_W'(counts_r[idx_r]) * C100_W'(PCT_FULL);
    end
    if (state_r == S_QWALK) begin
      if (hit || last) begin
        pres_r <= last ? highest_r : BOUND_TAB[idx_r];
      end else begin
        acc100_r <= acc_sum;
        c100_r   <= C100_W'(counts_r[idx_inc]) * C100_W'(PCT_FULL);
        idx_r    <= idx_inc;
      end
    end
    if (out_load) begin
      out_tdata_r <= {4'd0, highest_r, lowest_r, sum_r, total_ext[31:0], pres_r,
                      4'(bidx_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `LHP_ASSERT_NEXT(a_record_enters_update, in_acc && op == OP_RECORD,
                   state_r == S_REC, "record transaction did not reach the update step")
  `LHP_ASSERT_NEXT(a_count_after_record, state_r == S_REC,
                   total_r != '0, "total count is zero after a record")
  `LHP_ASSERT_NOW(a_walk_index_range, state_r == S_QWALK,
                  idx_r < BIDX_W'(NUM_BUCKETS), "bucket walk index out of range")
  `LHP_ASSERT_NOW(a_no_empty_answer, state_r == S_DONE && total_r != '0,
                  pres_r != '1, "empty answer reported for a populated histogram")

endmodule
